/* rtl/dcmef_pkg.sv */
// Shared types, record codes and helpers for the DICOM element framer.
package dcmef_pkg;

  // Input item: one raw file byte plus end-of-file flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  // Result item; fields that do not belong to the record kind are zero
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] tag;
    logic [15:0] vr_chars;
    logic [31:0] value_length;
    logic        explicit_vr;
    logic        long_length_form;
    logic [7:0]  value_byte;
    logic        value_end;
    logic [1:0]  end_status;
    logic        last;
  } out_item_t;

  // Record kinds
  localparam logic [1:0] REC_HEADER = 2'd0;
  localparam logic [1:0] REC_VALUE  = 2'd1;
  localparam logic [1:0] REC_STATUS = 2'd2;

  // End-of-stream status codes
  localparam logic [1:0] ST_CLEAN    = 2'd0;
  localparam logic [1:0] ST_NO_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  // Magic as it sits in the window: 'D' in the low byte, 'M' in the high byte
  localparam logic [31:0] MAGIC_WORD = 32'h4D43_4944;

  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // Window fill saturates once four bytes are in
  localparam logic [2:0] FILL_FULL = 3'd4;

  // Header byte positions
  localparam logic [3:0] HC_TAG_END  = 4'd4;
  localparam logic [3:0] HC_W1_END   = 4'd6;
  localparam logic [3:0] HC_W2_LAST  = 4'd7;
  localparam logic [3:0] HC_LEN_LAST = 4'd11;

  // Queue between parser and emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Parser phase
  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEAD,
    PH_VALUE,
    PH_BAD
  } phase_t;

  // One queue entry: an optional data record and an optional status record
  typedef struct packed {
    logic       rec_valid;
    out_item_t  rec;
    logic       stat_valid;
    logic [1:0] stat;
  } q_entry_t;

  function automatic logic printable(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

  function automatic out_item_t status_record(input logic [1:0] st);
    out_item_t r;
    r             = '0;
    r.record_kind = REC_STATUS;
    r.end_status  = st;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

/* rtl/dcmef_front.sv */
// Byte parser: magic search, element header framing and value byte tagging.
module dcmef_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  dcmef_pkg::in_item_t in_data,
  output logic                push,
  output dcmef_pkg::q_entry_t push_data
);
  import dcmef_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] win_r, win_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [15:0] w1_r, w1_nxt;
  logic [15:0] w2_r, w2_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;

  // Next state and the records caused by this byte
  always_comb begin
    logic [7:0]  b;
    logic        emit;
    logic        expl;
    logic        lng;
    logic [31:0] elen;
    logic [31:0] dec;
    b         = in_data.data_byte;
    emit      = 1'b0;
    expl      = 1'b0;
    lng       = 1'b0;
    elen      = '0;
    dec       = left_r - 32'd1;
    phase_nxt = phase_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    tag_nxt   = tag_r;
    w1_nxt    = w1_r;
    w2_nxt    = w2_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    push_data = '0;

    unique case (phase_r)
      PH_SEARCH: begin
        win_nxt = {b, win_r[31:8]};
        if (fill_r < FILL_FULL) fill_nxt = fill_r + 3'd1;
        if (fill_nxt == FILL_FULL && win_nxt[7:0] != 8'd0 && win_nxt[15:8] != 8'd0 &&
            win_nxt[23:16] != 8'd0 && win_nxt[31:24] != 8'd0) begin
          if (win_nxt == MAGIC_WORD) begin
            phase_nxt = PH_HEAD;
            count_nxt = '0;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
      end
      PH_HEAD: begin
        // Byte lanes fill in order, so each lane is simply overwritten
        if (count_r < HC_TAG_END) begin
          tag_nxt[8*count_r[1:0] +: 8] = b;
        end else if (count_r < HC_W1_END) begin
          w1_nxt[8*count_r[0] +: 8] = b;
        end else if (count_r <= HC_W2_LAST) begin
          w2_nxt[8*count_r[0] +: 8] = b;
        end else begin
          len_nxt[8*count_r[1:0] +: 8] = b;
        end
        count_nxt = count_r + 4'd1;
        expl = printable(w1_r[7:0]) && printable(w1_r[15:8]);
        if (count_r == HC_W2_LAST) begin
          if (!expl) begin
            emit = 1'b1;
            elen = {w2_nxt, w1_r};
          end else if (w2_nxt != 16'd0) begin
            emit = 1'b1;
            elen = {16'd0, w2_nxt};
          end
        end else if (count_r == HC_LEN_LAST) begin
          emit = 1'b1;
          lng  = 1'b1;
          elen = len_nxt;
        end
        if (emit) begin
          push_data.rec_valid            = 1'b1;
          push_data.rec.record_kind      = REC_HEADER;
          push_data.rec.tag              = tag_nxt;
          push_data.rec.vr_chars         = w1_nxt;
          push_data.rec.value_length     = elen;
          push_data.rec.explicit_vr      = expl;
          push_data.rec.long_length_form = lng;
          count_nxt                      = '0;
          if (elen != 32'd0) begin
            left_nxt  = elen;
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        push_data.rec_valid       = 1'b1;
        push_data.rec.record_kind = REC_VALUE;
        push_data.rec.value_byte  = b;
        push_data.rec.value_end   = (dec == 32'd0);
        left_nxt                  = dec;
        if (dec == 32'd0) phase_nxt = PH_HEAD;
      end
      PH_BAD: begin
      end
      default: begin
      end
    endcase

    // End of file: status from the updated phase, then back to reset state
    if (in_data.stream_end) begin
      push_data.stat_valid = 1'b1;
      if (phase_nxt == PH_SEARCH)                          push_data.stat = ST_NO_MAGIC;
      else if (phase_nxt == PH_BAD)                        push_data.stat = ST_BAD;
      else if (phase_nxt == PH_HEAD && count_nxt == 4'd0)  push_data.stat = ST_CLEAN;
      else                                                 push_data.stat = ST_TRUNC;
      phase_nxt = PH_SEARCH;
      fill_nxt  = '0;
      count_nxt = '0;
    end
  end

  assign push = acc && (push_data.rec_valid || push_data.stat_valid);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      fill_r  <= '0;
      count_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    if (acc) begin
      win_r  <= win_nxt;
      tag_r  <= tag_nxt;
      w1_r   <= w1_nxt;
      w2_r   <= w2_nxt;
      len_r  <= len_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

/* rtl/dcmef_queue.sv */
// Small FIFO of parsed entries between parser and record emitter.
module dcmef_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dcmef_pkg::q_entry_t push_data,
  input  logic                pop,
  output dcmef_pkg::q_entry_t head,
  output logic                full,
  output logic                empty
);
  import dcmef_pkg::*;

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  // Pointer and count update
  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

/* rtl/dcmef_back.sv */
// Record emitter: splits queue entries into result items behind an output register.
module dcmef_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dcmef_pkg::q_entry_t  head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcmef_pkg::out_item_t out_data
);
  import dcmef_pkg::*;

  logic       valid_r, valid_nxt;
  out_item_t  data_r, data_nxt;
  logic       pend_r, pend_nxt;
  logic [1:0] pend_st_r, pend_st_nxt;

  // Load the output register whenever it is empty or being taken
  always_comb begin
    logic load;
    load        = !valid_r || out_ready;
    pop         = 1'b0;
    valid_nxt   = valid_r;
    data_nxt    = data_r;
    pend_nxt    = pend_r;
    pend_st_nxt = pend_st_r;
    if (load) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        data_nxt  = status_record(pend_st_r);
        pend_nxt  = 1'b0;
      end else if (!empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        if (head.rec_valid) begin
          data_nxt      = head.rec;
          data_nxt.last = !head.stat_valid;
          pend_nxt      = head.stat_valid;
          pend_st_nxt   = head.stat;
        end else begin
          data_nxt = status_record(head.stat);
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    pend_st_r <= pend_st_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/dicom_element_framer_core.sv */
// Top level of the DICOM element framer: parser, entry queue and record emitter.
// The block takes one file byte per cycle while in_ready is high. It scans for
// the first window of four nonzero bytes, requires it to read DICM, then frames
// elements: one header record per element, one record per value byte (the last
// one flagged), and one status record on the byte marked stream_end. A byte's
// entry is written into the queue as the byte is accepted; its first record is
// then loaded from the queue head into the output register. The emitter sends
// one record per cycle while out_ready is high, so a byte that both completes a
// header or carries a value byte and ends the stream yields two records; input
// ready drops only when the four-entry queue between parser and emitter is full,
// which happens only under output stall.
module dicom_element_framer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcmef_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcmef_pkg::out_item_t out_data
);
  import dcmef_pkg::*;

  logic     acc;
  logic     push;
  q_entry_t push_data;
  logic     pop;
  q_entry_t head;
  logic     full;
  logic     empty;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  dcmef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  dcmef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  dcmef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
